/* hw/rtl/isat_pkg.sv */
// ----------------------------------------------------------------------------
// isat_pkg
// Shared types and constants for the indexed shift array table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isat_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ELEM_BITS_DEF = 32;
  localparam int OP_W          = 2;
  localparam int POS_W         = 5;
  localparam int VAL_W         = 32;
  localparam int STATUS_W      = 2;
  localparam int CNT_W         = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_APPEND = 2'd1,
    SH_INSERT = 2'd2,
    SH_REMOVE = 2'd3
  } shift_t;

  typedef struct packed {
    shift_t kind;
  } cell_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [CNT_W-1:0]    count;
  } out_word_t;

endpackage

/* hw/rtl/isat_cell.sv */
// ----------------------------------------------------------------------------
// isat_cell
// One table slot: holds, loads new data, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isat_cell #(
  parameter int ELEMENT_BITS = 32,
  parameter int IW           = 5,
  parameter int INDEX        = 0
) (
  input  logic                    clk,
  input  isat_pkg::cell_cmd_t     cmd,
  input  logic [IW-1:0]           sel,
  input  logic [ELEMENT_BITS-1:0] din,
  input  logic [ELEMENT_BITS-1:0] left,
  input  logic [ELEMENT_BITS-1:0] right,
  output logic [ELEMENT_BITS-1:0] q
);
  import isat_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic at_sel;
  logic above_sel;

  assign at_sel    = (MY_IDX == sel);
  assign above_sel = (MY_IDX > sel);

  always_ff @(posedge clk) begin
    case (cmd.kind)
      SH_APPEND: begin
        if (at_sel) q <= din;
      end
      SH_INSERT: begin
        if (at_sel) q <= din;
        else if (above_sel) q <= left;
      end
      SH_REMOVE: begin
        if (at_sel || above_sel) q <= right;
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

/* hw/rtl/isat_ctrl.sv */
// ----------------------------------------------------------------------------
// isat_ctrl
// Range and full checks, new count and the command broadcast to the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isat_ctrl #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  logic                       accept,
  input  logic [isat_pkg::OP_W-1:0]  operation,
  input  logic [isat_pkg::POS_W-1:0] position,
  input  logic [CW-1:0]              held,
  output isat_pkg::cell_cmd_t        cmd,
  output logic [CW-1:0]              sel,
  output isat_pkg::status_t          status,
  output logic [CW-1:0]              held_next
);
  import isat_pkg::*;

  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [XW-1:0] posx;
  logic [XW-1:0] heldx;
  logic          full;
  shift_t        kind;

  assign posx  = XW'(position);
  assign heldx = XW'(held);
  assign full  = (held == FULL_CNT);

  always_comb begin
    status    = ST_DONE;
    kind      = SH_HOLD;
    held_next = held;
    sel       = CW'(position);
    case (operation)
      OP_APPEND: begin
        sel = held;
        if (full) begin
          status = ST_FULL;
        end else begin
          kind      = SH_APPEND;
          held_next = held + CW'(1);
        end
      end
      OP_INSERT: begin
        if (posx > heldx) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          kind      = SH_INSERT;
          held_next = held + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (posx >= heldx) begin
          status = ST_RANGE;
        end else begin
          kind      = SH_REMOVE;
          held_next = held - CW'(1);
        end
      end
      default: begin
        if (posx >= heldx) status = ST_RANGE;
      end
    endcase
    cmd.kind = accept ? kind : SH_HOLD;
  end

endmodule

/* hw/rtl/indexed_shift_array_table.sv */
// ----------------------------------------------------------------------------
// indexed_shift_array_table
// Result: a word's result is in the output register in the cycle after accept.
// Throughput: one word per cycle while the output is not stalled; each cell
// settles its own shift from one broadcast command, for insert and remove alike.
// Reset: rst (sync) clears the element count and the output valid; the
// entry cells are not cleared and only written slots are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_shift_array_table #(
  parameter int DEPTH        = isat_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = isat_pkg::ELEM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isat_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output isat_pkg::out_word_t out_data
);
  import isat_pkg::*;

  // count needs DEPTH + 1 codes, cell index needs DEPTH codes
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IXW = $clog2(DEPTH);

  logic                    accept;
  logic [CW-1:0]           held;
  logic [CW-1:0]           held_next;
  logic [CW-1:0]           sel;
  cell_cmd_t               cmd;
  status_t                 status;
  logic [ELEMENT_BITS-1:0] din;
  logic [ELEMENT_BITS-1:0] cell_q [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_elem;
  logic [VAL_W-1:0]        rd_word;

  // Output register splits the two sides: a new word is taken whenever
  // the held result is gone or leaves this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // value is cut (or zero-padded) to the element width
  logic [ELEMENT_BITS+VAL_W-1:0] din_wide;
  assign din_wide = {{ELEMENT_BITS{1'b0}}, in_data.value};
  assign din      = din_wide[ELEMENT_BITS-1:0];

  isat_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .accept    (accept),
    .operation (in_data.operation),
    .position  (in_data.position),
    .held      (held),
    .cmd       (cmd),
    .sel       (sel),
    .status    (status),
    .held_next (held_next)
  );

  // Chain of cells. Cell i sees its lower neighbor (for insert) and its
  // upper neighbor (for remove); the ends tie off to values never read back.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_q;
    logic [ELEMENT_BITS-1:0] right_q;
    if (i == 0) begin : g_lo
      assign left_q = din;
    end else begin : g_lo
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign right_q = cell_q[i];
    end else begin : g_hi
      assign right_q = cell_q[i+1];
    end
    isat_cell #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .IW           (CW),
      .INDEX        (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .sel   (sel),
      .din   (din),
      .left  (left_q),
      .right (right_q),
      .q     (cell_q[i])
    );
  end

  // read port: position is below the count whenever the result is used
  assign rd_elem = cell_q[IXW'(in_data.position)];

  logic [ELEMENT_BITS+VAL_W-1:0] rd_wide;
  assign rd_wide = {{VAL_W{1'b0}}, rd_elem};
  assign rd_word = rd_wide[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.status     <= status;
      out_data.count      <= CNT_W'(held_next);
      out_data.read_value <= ((in_data.operation == OP_READ) && (status == ST_DONE))
                             ? rd_word : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(DEPTH))
    else $error("element count above capacity");

  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && (status != ST_DONE)) |=> (held == $past(held)))
    else $error("failed operation changed the count");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.count == CNT_W'(held)))
    else $error("reported count differs from held count");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
